// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TGR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define TGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tgr_pkg.sv =====
`timescale 1ns / 1ps

package tgr_pkg;

  localparam logic       ACT_LOAD = 1'b0;
  localparam logic       ACT_DRAW = 1'b1;
  localparam logic [7:0] CHAR_END = 8'h00;

  localparam int unsigned ADVANCE    = 10;
  localparam int unsigned WRAP_LIMIT = 320 - 10;
  localparam int unsigned LINE_STEP  = 20;

  localparam int unsigned FW_BITS   = 11;
  localparam int unsigned ADDR_BITS = 20;
  localparam logic [FW_BITS-1:0] FW_RESET = 11'd320;

  localparam logic REG_FRAME_WIDTH = 1'b0;

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
    logic [3:0] glyph_row;
    logic [7:0] row_bits;
    logic       start_flag;
    logic [9:0] start_x;
    logic [9:0] start_y;
    logic [7:0] ink_color;
  } tgr_in_t;

  typedef struct packed {
    logic [19:0] pixel_address;
    logic [7:0]  pixel_mask;
    logic [7:0]  pixel_color;
    logic        last_row;
  } tgr_out_t;

  typedef struct packed {
    logic font_wr;
    logic draw_start;
    logic mul;
    logic base;
    logic emit;
  } tgr_cmd_t;

  typedef struct packed {
    logic row_last;
    logic code_end;
  } tgr_status_t;

endpackage

// ===== rtl/core/tgr_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgr_datapath #(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256,
  parameter int COORD_BITS  = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tgr_pkg::tgr_cmd_t         cmd,
  input  tgr_pkg::tgr_in_t          in_data,
  input  logic [tgr_pkg::FW_BITS-1:0] frame_width,
  output tgr_pkg::tgr_out_t         out_data,
  output tgr_pkg::tgr_status_t      status
);
  import tgr_pkg::*;

  localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RB    = $clog2(GLYPH_ROWS);
  localparam int PW    = COORD_BITS + FW_BITS;
  localparam int CW    = COORD_BITS + 1;

  logic [7:0]            font_mem [DEPTH];
  logic [7:0]            rdata_r;
  logic [AW-1:0]         wr_idx;
  logic [AW-1:0]         rd_idx;
  logic                  wr_ok;

  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] line_r, line_nxt;
  logic [RB-1:0]         row_r, row_nxt;
  logic [7:0]            code_r, code_nxt;
  logic [7:0]            ink_r;
  logic                  oor_r;
  logic [PW-1:0]         prod_r;
  logic [ADDR_BITS-1:0]  acc_r;
  tgr_out_t              out_r;

  logic [CW-1:0]         col_plus;
  logic [CW-1:0]         line_plus;
  logic                  row_last;

  assign row_last  = (row_r == RB'(GLYPH_ROWS - 1));
  assign col_plus  = {1'b0, col_r} + CW'(ADVANCE);
  assign line_plus = {1'b0, line_r} + CW'(LINE_STEP);

  assign wr_ok  = (int'(in_data.char_code) < GLYPH_COUNT) &&
                  (int'(in_data.glyph_row) < GLYPH_ROWS);
  assign wr_idx = AW'(int'(in_data.char_code) * GLYPH_ROWS + int'(in_data.glyph_row));

  always_comb begin
    code_nxt = cmd.draw_start ? in_data.char_code : code_r;
    if (cmd.draw_start) begin
      row_nxt = '0;
    end else if (cmd.emit) begin
      row_nxt = row_last ? '0 : row_r + RB'(1);
    end else begin
      row_nxt = row_r;
    end
  end

  // Read address follows the next row so the registered data matches row_r.
  assign rd_idx = AW'(int'(code_nxt) * GLYPH_ROWS + int'(row_nxt));

  always_ff @(posedge clk) begin
    if (cmd.font_wr && wr_ok) begin
      font_mem[wr_idx] <= in_data.row_bits;
    end
    rdata_r <= font_mem[rd_idx];
  end

  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    if (cmd.draw_start && in_data.start_flag) begin
      col_nxt  = COORD_BITS'(in_data.start_x);
      line_nxt = COORD_BITS'(in_data.start_y);
    end else if (cmd.emit && row_last) begin
      if (col_plus > CW'(WRAP_LIMIT)) begin
        col_nxt  = '0;
        line_nxt = line_plus[COORD_BITS] ? '1 : line_plus[COORD_BITS-1:0];
      end else begin
        col_nxt = col_plus[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
      row_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
      row_r  <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    if (cmd.draw_start) begin
      ink_r <= in_data.ink_color;
      oor_r <= (int'(in_data.char_code) >= GLYPH_COUNT);
    end
    if (cmd.mul) begin
      prod_r <= PW'(line_r) * PW'(frame_width);
    end
    if (cmd.base) begin
      acc_r <= ADDR_BITS'(prod_r) + ADDR_BITS'(col_r);
    end else if (cmd.emit) begin
      acc_r <= acc_r + ADDR_BITS'(frame_width);
    end
    if (cmd.emit) begin
      out_r.pixel_address <= acc_r;
      out_r.pixel_mask    <= oor_r ? 8'h00 : rdata_r;
      out_r.pixel_color   <= ink_r;
      out_r.last_row      <= row_last;
    end
  end

  assign out_data        = out_r;
  assign status.row_last = row_last;
  assign status.code_end = (in_data.char_code == CHAR_END);

  `TGR_ASSERT_NEXT(a_last_flag, cmd.emit && row_last, out_r.last_row,
                   "final row word not marked last")
  `TGR_ASSERT_NEXT(a_row_wrap, cmd.emit && row_last && !cmd.draw_start, row_r == '0,
                   "row counter did not return to the top row after the last row")

endmodule

// ===== rtl/core/tgr_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tgr_pkg::tgr_status_t status,
  output tgr_pkg::tgr_cmd_t    cmd
);
  import tgr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_BASE,
    S_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   emit;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = (state_r == S_RUN) && (!out_valid_r || out_ready);

  always_comb begin
    cmd            = '0;
    cmd.font_wr    = accept && (in_action == ACT_LOAD);
    cmd.draw_start = accept && (in_action == ACT_DRAW);
    cmd.mul        = (state_r == S_MUL);
    cmd.base       = (state_r == S_BASE);
    cmd.emit       = emit;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.draw_start && !status.code_end) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:  state_nxt = S_BASE;
      S_BASE: state_nxt = S_RUN;
      S_RUN: begin
        if (emit && status.row_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // hold the word until taken; reload on every emit
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TGR_ASSERT_NEXT(a_draw_starts, cmd.draw_start && !status.code_end, state_r == S_MUL,
                   "nonzero draw did not start the sequence")
  `TGR_ASSERT_NEXT(a_done_idle, emit && status.row_last, state_r == S_IDLE && out_valid_r,
                   "last row did not end the draw with a word pending")
  `TGR_ASSERT(a_no_emit_idle, !(in_ready && emit),
              "row word emitted while taking input")

endmodule

// ===== rtl/core/text_glyph_renderer.sv =====
`timescale 1ns / 1ps

// Bitmap text renderer for 8-pixel-wide glyphs. Each input word either
// loads one font row or draws one character at the cursor. A draw
// forms the row-0 frame address after its accept, first by a multiply of
// cursor line by frame_width and then by the column add, and then emits
// GLYPH_ROWS masked row writes, one a cycle while the result side does
// not stall, through the registered read port of the font memory.
// A terminator draw (code 0) emits nothing. The output register lets the
// block take the next input word while the last row write still waits.
// The font memory has no reset; glyphs must be loaded before use.
module text_glyph_renderer #(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256,
  parameter int COORD_BITS  = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tgr_pkg::tgr_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tgr_pkg::tgr_out_t  out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tgr_pkg::*;

  logic [FW_BITS-1:0] frame_width_r;
  tgr_cmd_t           cmd;
  tgr_status_t        status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= FW_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_WIDTH)) begin
      frame_width_r <= pwdata[FW_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAME_WIDTH) begin
      prdata = {{(32 - FW_BITS){1'b0}}, frame_width_r};
    end
  end

  tgr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_data.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tgr_datapath #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .frame_width (frame_width_r),
    .out_data    (out_data),
    .status      (status)
  );

endmodule
